// ===== design/lspd_pkg.sv =====
package lspd_pkg;

  // packet constants
  localparam logic [7:0] HEADER_CODE   = 8'h57;
  localparam logic [7:0] CRC_POLY      = 8'h31;
  localparam logic [7:0] DIST_MASK     = 8'h3F;
  localparam logic [5:0] DIST_NONE     = 6'd63;
  localparam logic [3:0] STATUS_STRIKE = 4'd8;
  localparam logic [3:0] STATUS_START  = 4'd0;

  // byte positions within a packet
  localparam logic [3:0] POS_HEADER = 4'd0;
  localparam logic [3:0] POS_ID_HI  = 4'd1;
  localparam logic [3:0] POS_ID_MID = 4'd2;
  localparam logic [3:0] POS_ID_LO  = 4'd3;
  localparam logic [3:0] POS_BATT   = 4'd4;
  localparam logic [3:0] POS_DIST   = 4'd5;
  localparam logic [3:0] POS_COUNT  = 4'd6;
  localparam logic [3:0] POS_LAST   = 4'd8;
  localparam logic [3:0] POS_IDLE   = 4'd9;

  // stream widths
  localparam int S_TDATA_W = 16;
  localparam int M_TDATA_W = 48;
  localparam int M_TUSER_W = 2;

  // one decoded packet
  typedef struct packed {
    logic        packet_valid;
    logic        header_match;
    logic [19:0] sensor_id;
    logic        battery_low;
    logic [7:0]  strength_out;
    logic [7:0]  strike_count;
    logic        count_valid;
    logic [5:0]  distance_km;
  } lspd_result_t;

  // crc-8, msb first, one byte
  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
    end
    return c;
  endfunction

endpackage

// ===== design/lspd_out_buf.sv =====
module lspd_out_buf (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  lspd_pkg::lspd_result_t push_data,
  input  logic                  out_ready,
  output logic                  out_valid,
  output lspd_pkg::lspd_result_t out_data,
  output logic                  full
);

  logic                   skid_valid;
  lspd_pkg::lspd_result_t skid_data;
  logic                   pop;

  assign pop  = out_valid && out_ready;
  assign full = skid_valid;

  // control: output slot plus one skid slot
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop) begin
      if (skid_valid) begin
        skid_valid <= 1'b0;
      end else begin
        out_valid <= push;
      end
    end else if (push) begin
      if (out_valid) begin
        skid_valid <= 1'b1;
      end else begin
        out_valid <= 1'b1;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (pop) begin
      if (skid_valid) begin
        out_data <= skid_data;
      end else if (push) begin
        out_data <= push_data;
      end
    end else if (push) begin
      if (out_valid) begin
        skid_data <= push_data;
      end else begin
        out_data <= push_data;
      end
    end
  end

endmodule

// ===== design/lightning_sensor_packet_decoder_core.sv =====
// a packet's result is registered from its ninth byte, in the skid slot if a result is pending
// throughput: one byte beat per cycle; s_axis_tready drops only while both result slots are full
// a packet of nine bytes gives one result; a new start before that drops the packet silently
// reset (rst, synchronous, active high) sets the decoder idle, clears the running crc, sum
// and captured fields, and empties the result slots
module lightning_sensor_packet_decoder_core (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // data_byte [7:0], signal_dbm [15:8]
  input  logic [lspd_pkg::S_TDATA_W-1:0]  s_axis_tdata,
  // frame_start [0]
  input  logic [0:0]                      s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // sensor_id [19:0], battery_low [20], strength_out [28:21], strike_count [36:29],
  // count_valid [37], distance_km [43:38], zero [47:44]
  output logic [lspd_pkg::M_TDATA_W-1:0]  m_axis_tdata,
  // packet_valid [0], header_match [1]
  output logic [lspd_pkg::M_TUSER_W-1:0]  m_axis_tuser
);

  logic        in_acc;
  logic [7:0]  data_byte;
  logic        frame_start;
  logic [7:0]  signal_dbm;

  logic [3:0]  byte_position, byte_position_next;
  logic [7:0]  crc, crc_next;
  logic [7:0]  sum, sum_next;
  logic        header_ok, header_ok_next;
  logic [3:0]  status_nibble, status_nibble_next;
  logic [19:0] id_bits, id_bits_next;
  logic [1:0]  battery_bits, battery_bits_next;
  logic [5:0]  distance_raw, distance_raw_next;
  logic [7:0]  count_raw, count_raw_next;
  logic [7:0]  held_strength, held_strength_next;

  logic [3:0]  pos_c;
  logic [7:0]  crc_c;
  logic [7:0]  sum_c;
  logic        run;
  logic        chk_ok;
  logic        push;
  lspd_pkg::lspd_result_t res;
  lspd_pkg::lspd_result_t out_res;
  logic        buf_full;

  assign data_byte   = s_axis_tdata[7:0];
  assign signal_dbm  = s_axis_tdata[15:8];
  assign frame_start = s_axis_tuser[0];
  assign s_axis_tready = !buf_full;
  assign in_acc = s_axis_tvalid && s_axis_tready;

  // per-byte decode and packet check
  always_comb begin
    byte_position_next = byte_position;
    crc_next           = crc;
    sum_next           = sum;
    header_ok_next     = header_ok;
    status_nibble_next = status_nibble;
    id_bits_next       = id_bits;
    battery_bits_next  = battery_bits;
    distance_raw_next  = distance_raw;
    count_raw_next     = count_raw;
    held_strength_next = held_strength;
    pos_c  = byte_position;
    crc_c  = crc;
    sum_c  = sum;
    run    = 1'b0;
    chk_ok = 1'b0;
    push   = 1'b0;
    res    = '0;

    if (in_acc) begin
      if (frame_start) begin
        pos_c = lspd_pkg::POS_HEADER;
        crc_c = 8'd0;
        sum_c = 8'd0;
        held_strength_next = signal_dbm;
        run = 1'b1;
      end else begin
        run = (byte_position < lspd_pkg::POS_IDLE);
      end
    end

    if (run) begin
      if (pos_c < lspd_pkg::POS_LAST) begin
        crc_next = lspd_pkg::crc8_update(crc_c, data_byte);
        sum_next = sum_c + data_byte;
        byte_position_next = pos_c + 4'd1;
        case (pos_c)
          lspd_pkg::POS_HEADER: header_ok_next = (data_byte == lspd_pkg::HEADER_CODE);
          lspd_pkg::POS_ID_HI: begin
            status_nibble_next  = data_byte[7:4];
            id_bits_next[19:16] = data_byte[3:0];
          end
          lspd_pkg::POS_ID_MID: id_bits_next[15:8] = data_byte;
          lspd_pkg::POS_ID_LO:  id_bits_next[7:0]  = data_byte;
          lspd_pkg::POS_BATT:   battery_bits_next  = data_byte[2:1];
          lspd_pkg::POS_DIST:   distance_raw_next  = data_byte[5:0] & lspd_pkg::DIST_MASK[5:0];
          lspd_pkg::POS_COUNT:  count_raw_next     = data_byte;
          default: ;
        endcase
      end else begin
        // ninth byte: check crc residue and sum, emit
        byte_position_next = lspd_pkg::POS_IDLE;
        chk_ok = (crc_c == 8'd0) && (sum_c == data_byte);
        push   = 1'b1;
        res.packet_valid = chk_ok;
        res.header_match = header_ok;
        res.strength_out = held_strength;
        res.distance_km  = lspd_pkg::DIST_NONE;
        if (chk_ok) begin
          res.sensor_id    = id_bits;
          res.battery_low  = (battery_bits == 2'b00);
          res.strike_count = count_raw;
          res.count_valid  = (status_nibble != lspd_pkg::STATUS_START);
          if (status_nibble == lspd_pkg::STATUS_STRIKE) begin
            res.distance_km = distance_raw;
          end
        end
      end
    end
  end

  // decoder state
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= lspd_pkg::POS_IDLE;
      crc           <= 8'd0;
      sum           <= 8'd0;
      header_ok     <= 1'b0;
      status_nibble <= 4'd0;
      id_bits       <= 20'd0;
      battery_bits  <= 2'd0;
      distance_raw  <= 6'd0;
      count_raw     <= 8'd0;
      held_strength <= 8'd0;
    end else begin
      byte_position <= byte_position_next;
      crc           <= crc_next;
      sum           <= sum_next;
      header_ok     <= header_ok_next;
      status_nibble <= status_nibble_next;
      id_bits       <= id_bits_next;
      battery_bits  <= battery_bits_next;
      distance_raw  <= distance_raw_next;
      count_raw     <= count_raw_next;
      held_strength <= held_strength_next;
    end
  end

  // result register with skid slot
  lspd_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (res),
    .out_ready (m_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_data  (out_res),
    .full      (buf_full)
  );

  // pack output beat
  assign m_axis_tdata = {4'd0, out_res.distance_km, out_res.count_valid, out_res.strike_count,
                         out_res.strength_out, out_res.battery_low, out_res.sensor_id};
  assign m_axis_tuser = {out_res.header_match, out_res.packet_valid};

endmodule

// ===== design/lspd_checker.sv =====
module lspd_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_axis_tvalid,
  input logic                            s_axis_tready,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [lspd_pkg::M_TDATA_W-1:0]  m_axis_tdata,
  input logic [lspd_pkg::M_TUSER_W-1:0]  m_axis_tuser
);

  // stalled output beat stays
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser))
    else $error("stalled output beat changed");

  // a new result only follows an accepted input beat
  a_out_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready))
    else $error("result without input beat");

  // input stalls only while a result is pending
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("input stalled with no result pending");

  // failed packets carry cleared fields and no distance
  a_bad_fields: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata[20:0] == 21'd0
      && m_axis_tdata[37:29] == 9'd0 && m_axis_tdata[43:38] == lspd_pkg::DIST_NONE)
    else $error("failed packet with nonzero fields");

endmodule

bind lightning_sensor_packet_decoder_core lspd_checker u_lspd_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

// ===== test/tb_lightning_sensor_packet_decoder_core.sv =====
`timescale 1ns / 100ps

module tb_lightning_sensor_packet_decoder_core;

  localparam int CYCLE_LIMIT  = 100000;
  localparam int HOLD_CYCLES  = 150;
  localparam int IDLE_PCT     = 9;
  localparam int TARGET_BYTES = 650;

  // nine packet bytes, index 0 first on the wire
  typedef logic [0:8][7:0] pkt_t;

  // one row of the directed table
  typedef struct {
    logic [7:0]             data;
    logic                   start;
    logic [7:0]             dbm;
    bit                     pinned;
    lspd_pkg::lspd_result_t golden;
  } stim_row_t;

  logic                            clk;
  logic                            rst;
  logic                            s_axis_tvalid;
  logic                            s_axis_tready;
  logic [lspd_pkg::S_TDATA_W-1:0]  s_axis_tdata;
  logic [0:0]                      s_axis_tuser;
  logic                            m_axis_tvalid;
  logic                            m_axis_tready;
  logic [lspd_pkg::M_TDATA_W-1:0]  m_axis_tdata;
  logic [lspd_pkg::M_TUSER_W-1:0]  m_axis_tuser;

  // fixed expectation riding along with the beat on the bus
  bit                     beat_pinned;
  lspd_pkg::lspd_result_t beat_golden;

  // decoder state mirrored by the predictor
  logic [3:0]  pkt_pos;
  logic [7:0]  run_crc;
  logic [7:0]  run_sum;
  logic        hdr_ok;
  logic [3:0]  status_nib;
  logic [19:0] id_acc;
  logic [1:0]  batt_acc;
  logic [5:0]  dist_acc;
  logic [7:0]  count_acc;
  logic [7:0]  dbm_held;

  lspd_pkg::lspd_result_t packets_due[$];
  stim_row_t              dir_rows[$];

  int  fails;
  int  cycles;
  int  bytes_taken;
  int  packets_checked;
  int  packets_good;
  bit  steady;
  bit  hold_req;
  int  hold_left;

  lightning_sensor_packet_decoder_core u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d packets still due", cycles, packets_due.size());
      $display("** lightning_sensor_packet_decoder_core: FAILED **");
      $finish;
    end
  end

  // crc-8 poly 0x31, fed one bit at a time msb first
  function automatic logic [7:0] crc_step(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] r;
    logic       fb;
    r = crc;
    for (int i = 7; i >= 0; i--) begin
      fb = r[7] ^ b[i];
      r  = {r[6:0], 1'b0} ^ (fb ? lspd_pkg::CRC_POLY : 8'h00);
    end
    return r;
  endfunction

  // byte seven zeroes the crc residue, byte eight carries the sum
  function automatic pkt_t sealed(input pkt_t p);
    pkt_t       q;
    logic [7:0] c;
    logic [7:0] s;
    q = p;
    c = 8'h00;
    for (int i = 0; i < 7; i++) c = crc_step(c, q[i]);
    q[7] = c;
    s = 8'h00;
    for (int i = 0; i < 8; i++) s = s + q[i];
    q[8] = s;
    return q;
  endfunction

  // predictor: one byte in, maybe one decoded packet out
  function automatic bit decode_step(input logic [7:0] b, input logic start,
                                     input logic [7:0] dbm,
                                     output lspd_pkg::lspd_result_t res);
    bit ok;
    res = '0;
    if (start) begin
      pkt_pos  = lspd_pkg::POS_HEADER;
      run_crc  = 8'h00;
      run_sum  = 8'h00;
      dbm_held = dbm;
    end else if (pkt_pos >= lspd_pkg::POS_IDLE) begin
      return 1'b0;
    end
    bytes_taken++;
    if (pkt_pos < lspd_pkg::POS_LAST) begin
      run_crc = crc_step(run_crc, b);
      run_sum = run_sum + b;
      case (pkt_pos)
        lspd_pkg::POS_HEADER: hdr_ok = (b == lspd_pkg::HEADER_CODE);
        lspd_pkg::POS_ID_HI: begin
          status_nib     = b[7:4];
          id_acc[19:16]  = b[3:0];
        end
        lspd_pkg::POS_ID_MID: id_acc[15:8] = b;
        lspd_pkg::POS_ID_LO:  id_acc[7:0]  = b;
        lspd_pkg::POS_BATT:   batt_acc     = b[2:1];
        lspd_pkg::POS_DIST:   dist_acc     = b[5:0];
        lspd_pkg::POS_COUNT:  count_acc    = b;
        default: ;
      endcase
      pkt_pos = pkt_pos + 4'd1;
      return 1'b0;
    end
    // last byte closes the packet
    ok = (run_crc == 8'h00) && (run_sum == b);
    pkt_pos = lspd_pkg::POS_IDLE;
    res.packet_valid = ok;
    res.header_match = hdr_ok;
    res.strength_out = dbm_held;
    res.distance_km  = lspd_pkg::DIST_NONE;
    if (ok) begin
      res.sensor_id    = id_acc;
      res.battery_low  = (batt_acc == 2'b00);
      res.strike_count = count_acc;
      res.count_valid  = (status_nib != lspd_pkg::STATUS_START);
      res.distance_km  = (status_nib == lspd_pkg::STATUS_STRIKE) ? dist_acc
                                                                  : lspd_pkg::DIST_NONE;
    end
    return 1'b1;
  endfunction

  task automatic check_field(input string fname, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      fails++;
      $display("%0t mismatch on %s: expected 0x%0h, actual 0x%0h", $time, fname, want, got);
    end
  endtask

  // result checking and prediction, both on the rising edge
  always @(posedge clk) begin : monitor
    lspd_pkg::lspd_result_t want;
    lspd_pkg::lspd_result_t got;
    lspd_pkg::lspd_result_t pred;
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (packets_due.size() == 0) begin
          fails++;
          $display("%0t unexpected result beat: tdata 0x%0h tuser 0x%0h",
                   $time, m_axis_tdata, m_axis_tuser);
        end else begin
          want = packets_due.pop_front();
          got.packet_valid = m_axis_tuser[0];
          got.header_match = m_axis_tuser[1];
          got.sensor_id    = m_axis_tdata[19:0];
          got.battery_low  = m_axis_tdata[20];
          got.strength_out = m_axis_tdata[28:21];
          got.strike_count = m_axis_tdata[36:29];
          got.count_valid  = m_axis_tdata[37];
          got.distance_km  = m_axis_tdata[43:38];
          check_field("packet_valid", 32'(want.packet_valid), 32'(got.packet_valid));
          check_field("header_match", 32'(want.header_match), 32'(got.header_match));
          check_field("sensor_id", 32'(want.sensor_id), 32'(got.sensor_id));
          check_field("battery_low", 32'(want.battery_low), 32'(got.battery_low));
          check_field("strength_out", 32'(want.strength_out), 32'(got.strength_out));
          check_field("strike_count", 32'(want.strike_count), 32'(got.strike_count));
          check_field("count_valid", 32'(want.count_valid), 32'(got.count_valid));
          check_field("distance_km", 32'(want.distance_km), 32'(got.distance_km));
          packets_checked++;
          if (want.packet_valid) packets_good++;
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        if (decode_step(s_axis_tdata[7:0], s_axis_tuser[0], s_axis_tdata[15:8], pred))
          packets_due.push_back(beat_pinned ? beat_golden : pred);
      end
    end
  end

  // receiver: random tready, with a long hold-off on request
  initial begin
    bit hold_taken;
    hold_taken    = 1'b0;
    m_axis_tready = 1'b0;
    hold_left     = 0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_req && !hold_taken) begin
        hold_left  = HOLD_CYCLES;
        hold_taken = 1'b1;
      end
      if (hold_left > 0) begin
        m_axis_tready = 1'b0;
        hold_left--;
      end else begin
        m_axis_tready = steady || ($urandom_range(99) >= IDLE_PCT);
      end
      @(negedge clk);
    end
  end

  // one byte beat, with random idle cycles ahead of it unless steady is set
  task automatic send_beat(input logic [7:0] data, input logic start, input logic [7:0] dbm,
                           input bit pinned, input lspd_pkg::lspd_result_t golden);
    if (!steady) begin
      while ($urandom_range(99) < IDLE_PCT) begin
        s_axis_tvalid = 1'b0;
        @(negedge clk);
      end
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = {dbm, data};
    s_axis_tuser  = start;
    beat_pinned   = pinned;
    beat_golden   = golden;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic add_row(input logic [7:0] data, input logic start, input logic [7:0] dbm,
                         input bit pinned, input lspd_pkg::lspd_result_t golden);
    stim_row_t r;
    r.data   = data;
    r.start  = start;
    r.dbm    = dbm;
    r.pinned = pinned;
    r.golden = golden;
    dir_rows.push_back(r);
  endtask

  // random traffic: mostly well-formed packets, some broken ones and noise
  task automatic send_random_packet();
    pkt_t       p;
    logic [7:0] dbm;
    int         kind;
    int         len;
    kind = $urandom_range(99);
    dbm  = 8'($urandom);
    if (kind < 72) begin
      for (int i = 0; i < 9; i++) p[i] = 8'($urandom);
      if ($urandom_range(9) < 8) p[0] = lspd_pkg::HEADER_CODE;
      case ($urandom_range(3))
        0: p[1][7:4] = lspd_pkg::STATUS_START;
        1: p[1][7:4] = lspd_pkg::STATUS_STRIKE;
        default: ;
      endcase
      p = sealed(p);
      if ($urandom_range(9) == 0) p[7] = p[7] ^ 8'($urandom_range(255, 1));
      if ($urandom_range(9) == 0) p[8] = 8'($urandom);
      for (int i = 0; i < 9; i++) send_beat(p[i], i == 0, dbm, 1'b0, '0);
      // stray bytes after the packet are dropped
      if ($urandom_range(4) == 0) begin
        len = $urandom_range(3, 1);
        for (int i = 0; i < len; i++)
          send_beat(8'($urandom), 1'b0, 8'($urandom), 1'b0, '0);
      end
    end else if (kind < 87) begin
      // cut short, the next start abandons it
      len = $urandom_range(8, 1);
      for (int i = 0; i < len; i++) send_beat(8'($urandom), i == 0, dbm, 1'b0, '0);
    end else begin
      // noise with random start marks
      len = $urandom_range(12, 1);
      for (int i = 0; i < len; i++)
        send_beat(8'($urandom), $urandom_range(3) == 0, 8'($urandom), 1'b0, '0);
    end
  endtask

  // stimulus
  initial begin
    pkt_t                   pa;
    pkt_t                   pb;
    lspd_pkg::lspd_result_t ga;
    lspd_pkg::lspd_result_t gb;
    int                     mark;

    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    beat_pinned   = 1'b0;
    beat_golden   = '0;
    steady        = 1'b0;
    hold_req      = 1'b0;
    pkt_pos       = lspd_pkg::POS_IDLE;
    run_crc       = 8'h00;
    run_sum       = 8'h00;
    hdr_ok        = 1'b0;
    status_nib    = 4'h0;
    id_acc        = 20'h0;
    batt_acc      = 2'b00;
    dist_acc      = 6'h00;
    count_acc     = 8'h00;
    dbm_held      = 8'h00;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: byte before any start, full-scale good packet, short packet,
    // failed checks, stray byte after the end
    pa = sealed({8'h57, 8'h8F, 8'hFF, 8'hFF, 8'h00, 8'hC0, 8'hFF, 8'h00, 8'h00});
    ga = '{1'b1, 1'b1, 20'hFFFFF, 1'b1, 8'h80, 8'hFF, 1'b1, 6'd0};
    pb = {8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01};
    gb = '{1'b0, 1'b0, 20'h0, 1'b0, 8'h7F, 8'h00, 1'b0, lspd_pkg::DIST_NONE};
    add_row(8'hFF, 1'b0, 8'h00, 1'b0, '0);
    for (int i = 0; i < 9; i++) add_row(pa[i], i == 0, 8'h80, i == 8, ga);
    add_row(8'h57, 1'b1, 8'h11, 1'b0, '0);
    add_row(8'h8A, 1'b0, 8'h22, 1'b0, '0);
    add_row(8'h12, 1'b0, 8'h33, 1'b0, '0);
    for (int i = 0; i < 9; i++) add_row(pb[i], i == 0, 8'h7F, i == 8, gb);
    add_row(8'hA5, 1'b0, 8'hFF, 1'b0, '0);
    foreach (dir_rows[i])
      send_beat(dir_rows[i].data, dir_rows[i].start, dir_rows[i].dbm,
                dir_rows[i].pinned, dir_rows[i].golden);

    // random traffic with idling on both sides
    while (bytes_taken < 220) send_random_packet();

    // receiver holds off while bytes keep coming
    hold_req = 1'b1;
    mark = bytes_taken;
    while (bytes_taken < mark + 70) send_random_packet();

    // sender waits for every packet to drain
    s_axis_tvalid = 1'b0;
    while (packets_due.size() != 0) @(negedge clk);

    // back-to-back stretch with no idling
    steady = 1'b1;
    mark = bytes_taken;
    while (bytes_taken < mark + 150) send_random_packet();
    steady = 1'b0;

    while (bytes_taken < TARGET_BYTES) send_random_packet();
    s_axis_tvalid = 1'b0;

    while (packets_due.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);

    $display("decoded %0d bytes into %0d packets (%0d passed crc and sum checks)",
             bytes_taken, packets_checked, packets_good);
    $display("covered short and broken packets, stray bytes, a long output hold-off and a drain");
    if (fails == 0) begin
      $display("** lightning_sensor_packet_decoder_core: PASSED **");
    end else begin
      $display("%0d mismatches", fails);
      $display("** lightning_sensor_packet_decoder_core: FAILED **");
    end
    $finish;
  end

endmodule
